// File: rtl/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SEM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define SEM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/sem_pkg.sv
// Shared constants and types of the Sobel edge magnitude block.
package sem_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int PIX_W     = 8;
   localparam int MAG_W     = 11;
   localparam int COL_W     = 11;
   localparam int ROW_W     = 16;
   localparam int IMG_W_W   = 12;
   localparam int SUM_W     = 21;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam logic [MAG_W-1:0] MAG_CLAMP = MAG_W'(255);
   localparam logic [IMG_W_W-1:0] MIN_DIM = IMG_W_W'(3);

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_ROI_LEFT     = 3'd2;
   localparam logic [2:0] REG_ROI_TOP      = 3'd3;
   localparam logic [2:0] REG_ROI_COLS     = 3'd4;
   localparam logic [2:0] REG_ROI_ROWS     = 3'd5;
   localparam logic [2:0] REG_WIDE_OUTPUT  = 3'd6;

   typedef struct packed {
      logic [IMG_W_W-1:0] image_width;
      logic [ROW_W-1:0]   image_height;
      logic [COL_W-1:0]   roi_left;
      logic [ROW_W-1:0]   roi_top;
      logic [IMG_W_W-1:0] roi_cols;
      logic [ROW_W-1:0]   roi_rows;
      logic               wide_output;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic shift;
      logic pick;
      logic mult;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic geom_ok;
      logic mask_empty;
      logic root_done;
      logic out_free;
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SHIFT = 7'b0000010,
      ST_PICK  = 7'b0000100,
      ST_GRAD  = 7'b0001000,
      ST_MULT  = 7'b0010000,
      ST_ROOT  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

endpackage

// File: rtl/sem_csr.sv
// Configuration register bank on the APB-style port.
module sem_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sem_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sem_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sem_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output sem_pkg::cfg_type             cfg
);

   sem_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            sem_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_pwdata[11:0];
            sem_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = csr_pwdata[15:0];
            sem_pkg::REG_ROI_LEFT:     cfg_in.roi_left     = csr_pwdata[10:0];
            sem_pkg::REG_ROI_TOP:      cfg_in.roi_top      = csr_pwdata[15:0];
            sem_pkg::REG_ROI_COLS:     cfg_in.roi_cols     = csr_pwdata[11:0];
            sem_pkg::REG_ROI_ROWS:     cfg_in.roi_rows     = csr_pwdata[15:0];
            sem_pkg::REG_WIDE_OUTPUT:  cfg_in.wide_output  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         sem_pkg::REG_IMAGE_WIDTH:  csr_prdata = {20'd0, cfg_ff.image_width};
         sem_pkg::REG_IMAGE_HEIGHT: csr_prdata = {16'd0, cfg_ff.image_height};
         sem_pkg::REG_ROI_LEFT:     csr_prdata = {21'd0, cfg_ff.roi_left};
         sem_pkg::REG_ROI_TOP:      csr_prdata = {16'd0, cfg_ff.roi_top};
         sem_pkg::REG_ROI_COLS:     csr_prdata = {20'd0, cfg_ff.roi_cols};
         sem_pkg::REG_ROI_ROWS:     csr_prdata = {16'd0, cfg_ff.roi_rows};
         sem_pkg::REG_WIDE_OUTPUT:  csr_prdata = {31'd0, cfg_ff.wide_output};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/sem_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module sem_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sem_pkg::SUM_W-1:0]   value,
   output logic                        done,
   output logic [sem_pkg::MAG_W-1:0]   root
);

   localparam int STEPS = sem_pkg::MAG_W;
   localparam int VAL_W = 2 * STEPS;
   localparam int REM_W = sem_pkg::MAG_W + 3;

   logic [VAL_W-1:0]           val_ff, val_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [sem_pkg::MAG_W-1:0]  root_ff, root_in;
   logic [3:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [REM_W-1:0]           rem_sh;
   logic [REM_W-1:0]           trial;

   assign rem_sh = {rem_ff[REM_W-3:0], val_ff[VAL_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         val_in  = VAL_W'(value);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         val_in = {val_ff[VAL_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[sem_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[sem_pkg::MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/sem_ctrl.sv
// Sequencing state machine: accept, window update, per-result gradient, root and result load.
module sem_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sem_pkg::status_type status,
   output sem_pkg::cmd_type    cmd
);

   sem_pkg::state_type state_ff, state_in;

   assign req_stall = (state_ff != sem_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         sem_pkg::ST_IDLE: begin
            // an invalid geometry drops the word here
            if (req_valid && status.geom_ok) begin
               cmd.accept = 1'b1;
               state_in   = sem_pkg::ST_SHIFT;
            end
         end
         sem_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = sem_pkg::ST_PICK;
         end
         sem_pkg::ST_PICK: begin
            if (status.mask_empty) begin
               state_in = sem_pkg::ST_IDLE;
            end else begin
               cmd.pick = 1'b1;
               state_in = sem_pkg::ST_GRAD;
            end
         end
         sem_pkg::ST_GRAD: begin
            state_in = sem_pkg::ST_MULT;
         end
         sem_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = sem_pkg::ST_ROOT;
         end
         sem_pkg::ST_ROOT: begin
            if (status.root_done) begin
               state_in = sem_pkg::ST_EMIT;
            end
         end
         sem_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = sem_pkg::ST_PICK;
            end
         end
         default: state_in = sem_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sem_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/sem_datapath.sv
// Line stores, window, position counters, gradients and result register.
module sem_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  sem_pkg::cfg_type            cfg,
   input  sem_pkg::cmd_type            cmd,
   output sem_pkg::status_type         status,
   input  logic [sem_pkg::PIX_W-1:0]   req_pixel,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sem_pkg::MAG_W-1:0]   rsp_magnitude,
   output logic [sem_pkg::COL_W-1:0]   rsp_out_col,
   output logic [sem_pkg::ROW_W-1:0]   rsp_out_row,
   output logic                        rsp_run_last
);

   localparam int PW = sem_pkg::PIX_W;
   localparam int CW = sem_pkg::COL_W;
   localparam int RW = sem_pkg::ROW_W;
   localparam int IW = sem_pkg::IMG_W_W;

   logic [PW-1:0] upper_mem [sem_pkg::MAX_WIDTH];
   logic [PW-1:0] lower_mem [sem_pkg::MAX_WIDTH];
   logic [PW-1:0] upper_rd_ff, lower_rd_ff;

   // window: [column oldest..newest][row top..bottom]
   logic [PW-1:0] win_ff [3][3];

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] cur_c_ff;
   logic [RW-1:0] cur_r_ff;
   logic [PW-1:0] px_ff;
   logic [3:0]    mask_ff, mask_in;
   logic [1:0]    cand_ff, cand_in;
   logic signed [10:0] gx_ff, gy_ff;
   logic [sem_pkg::SUM_W-1:0] sum;
   logic          root_done;
   logic [sem_pkg::MAG_W-1:0] root;

   logic               rsp_valid_ff;
   logic [sem_pkg::MAG_W-1:0] mag_ff;
   logic [CW-1:0]      ocol_ff;
   logic [RW-1:0]      orow_ff;
   logic               last_ff;

   logic          geom_ok;
   logic [CW-1:0] nc;
   logic [RW-1:0] nr;
   logic [IW:0]   c_plus;
   logic [RW:0]   r_plus;

   // geometry check
   always_comb begin
      geom_ok = 1'b1;
      if (cfg.image_width < sem_pkg::MIN_DIM) geom_ok = 1'b0;
      if (cfg.image_width > IW'(sem_pkg::MAX_WIDTH)) geom_ok = 1'b0;
      if (cfg.image_height < RW'(sem_pkg::MIN_DIM)) geom_ok = 1'b0;
      if (cfg.roi_cols == '0 || cfg.roi_rows == '0) geom_ok = 1'b0;
      if ((IW+1)'(cfg.roi_left) + (IW+1)'(cfg.roi_cols) > (IW+1)'(cfg.image_width))
         geom_ok = 1'b0;
      if ((RW+1)'(cfg.roi_top) + (RW+1)'(cfg.roi_rows) > (RW+1)'(cfg.image_height))
         geom_ok = 1'b0;
   end

   // position of this word, restart if the counters fell outside the image
   always_comb begin
      if (IW'(col_ff) >= cfg.image_width || row_ff >= cfg.image_height) begin
         nc = '0;
         nr = '0;
      end else begin
         nc = col_ff;
         nr = row_ff;
      end
      c_plus = (IW+1)'(nc) + (IW+1)'(1);
      r_plus = (RW+1)'(nr) + (RW+1)'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.accept) begin
         if (c_plus >= (IW+1)'(cfg.image_width)) begin
            col_in = '0;
            if (r_plus >= (RW+1)'(cfg.image_height)) begin
               row_in = '0;
            end else begin
               row_in = r_plus[RW-1:0];
            end
         end else begin
            col_in = c_plus[CW-1:0];
            row_in = nr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         upper_rd_ff <= upper_mem[nc[sem_pkg::ADDR_W-1:0]];
         lower_rd_ff <= lower_mem[nc[sem_pkg::ADDR_W-1:0]];
         cur_c_ff    <= nc;
         cur_r_ff    <= nr;
         px_ff       <= req_pixel;
      end
      if (cmd.shift) begin
         upper_mem[cur_c_ff[sem_pkg::ADDR_W-1:0]] <= lower_rd_ff;
         lower_mem[cur_c_ff[sem_pkg::ADDR_W-1:0]] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (cmd.shift) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2][0] <= upper_rd_ff;
         win_ff[2][1] <= lower_rd_ff;
         win_ff[2][2] <= px_ff;
      end
   end

   // candidate centres: bit0 = (r-1,c-1), bit1 = last row (r,c-1),
   // bit2 = row end (r-1,c), bit3 = both (r,c)
   function automatic logic in_roi(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                   input sem_pkg::cfg_type g);
      logic ok;
      ok = 1'b1;
      if (c < g.roi_left) ok = 1'b0;
      if ((IW+1)'(c) >= (IW+1)'(g.roi_left) + (IW+1)'(g.roi_cols)) ok = 1'b0;
      if (r < g.roi_top) ok = 1'b0;
      if ((RW+1)'(r) >= (RW+1)'(g.roi_top) + (RW+1)'(g.roi_rows)) ok = 1'b0;
      return ok;
   endfunction

   logic base, last_row, row_end;
   logic [CW-1:0] cm1;
   logic [RW-1:0] rm1;

   assign cm1      = cur_c_ff - CW'(1);
   assign rm1      = cur_r_ff - RW'(1);
   assign base     = (cur_r_ff != '0) && (cur_c_ff != '0);
   assign last_row = (cur_r_ff == cfg.image_height - RW'(1));
   assign row_end  = (IW'(cur_c_ff) == cfg.image_width - IW'(1));

   // candidate geometry
   logic [CW-1:0] cand_col;
   logic [RW-1:0] cand_row;
   logic          cand_low;
   logic [1:0]    li, ci, ri;

   assign cand_col = cand_ff[1] ? cur_c_ff : cm1;
   assign cand_row = cand_ff[0] ? cur_r_ff : rm1;
   assign cand_low = cand_ff[0];

   always_comb begin
      if (cand_ff[1]) begin
         li = 2'd1; ci = 2'd2; ri = 2'd2;
      end else begin
         li = (cur_c_ff == CW'(1)) ? 2'd1 : 2'd0;
         ci = 2'd1; ri = 2'd2;
      end
   end

   always_comb begin
      mask_in = mask_ff;
      cand_in = cand_ff;
      if (cmd.shift) begin
         mask_in[0] = base && in_roi(rm1, cm1, cfg);
         mask_in[1] = base && last_row && in_roi(cur_r_ff, cm1, cfg);
         mask_in[2] = base && row_end && in_roi(rm1, cur_c_ff, cfg);
         mask_in[3] = base && last_row && row_end && in_roi(cur_r_ff, cur_c_ff, cfg);
      end else if (cmd.pick) begin
         // take the lowest pending candidate
         if (mask_ff[0]) begin
            cand_in = 2'd0; mask_in[0] = 1'b0;
         end else if (mask_ff[1]) begin
            cand_in = 2'd1; mask_in[1] = 1'b0;
         end else if (mask_ff[2]) begin
            cand_in = 2'd2; mask_in[2] = 1'b0;
         end else begin
            cand_in = 2'd3; mask_in[3] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      cand_ff <= cand_in;
   end

   // column taps with border replication
   function automatic logic [3*PW-1:0] take(input logic [PW-1:0] col [3],
                                           input logic low, input logic top);
      if (low) begin
         return {col[1], col[2], col[2]};
      end else begin
         return {(top ? col[1] : col[0]), col[1], col[2]};
      end
   endfunction

   logic [3*PW-1:0] ta, tb, tc;
   logic [PW+1:0]   sl, sr, st, sb;
   logic            top_edge;
   logic [1:0]      state_cnt;

   assign top_edge = (cand_row == '0);
   assign ta = take(win_ff[li], cand_low, top_edge);
   assign tb = take(win_ff[ci], cand_low, top_edge);
   assign tc = take(win_ff[ri], cand_low, top_edge);

   assign sl = (PW+2)'(ta[23:16]) + {1'b0, ta[15:8], 1'b0} + (PW+2)'(ta[7:0]);
   assign sr = (PW+2)'(tc[23:16]) + {1'b0, tc[15:8], 1'b0} + (PW+2)'(tc[7:0]);
   assign st = (PW+2)'(ta[23:16]) + {1'b0, tb[23:16], 1'b0} + (PW+2)'(tc[23:16]);
   assign sb = (PW+2)'(ta[7:0]) + {1'b0, tb[7:0], 1'b0} + (PW+2)'(tc[7:0]);

   // gradients register from the candidate latched at the pick
   always_ff @(posedge clock) begin
      gx_ff <= $signed({1'b0, sr}) - $signed({1'b0, sl});
      gy_ff <= $signed({1'b0, st}) - $signed({1'b0, sb});
   end

   logic signed [21:0] gx2, gy2;
   assign gx2 = gx_ff * gx_ff;
   assign gy2 = gy_ff * gy_ff;
   assign sum = sem_pkg::SUM_W'(gx2 + gy2);

   sem_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.mult),
      .value (sum),
      .done  (root_done),
      .root  (root)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         mag_ff  <= (!cfg.wide_output && root > sem_pkg::MAG_CLAMP) ?
                    sem_pkg::MAG_CLAMP : root;
         ocol_ff <= cand_col;
         orow_ff <= cand_row;
         last_ff <= (mask_ff == '0);
      end
   end

   assign state_cnt = '0;
   assign status.geom_ok    = geom_ok | (|state_cnt);
   assign status.mask_empty = (mask_ff == '0);
   assign status.root_done  = root_done;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_out_col   = ocol_ff;
   assign rsp_out_row   = orow_ff;
   assign rsp_run_last  = last_ff;

endmodule

// File: rtl/sobel_edge_magnitude.sv
// Top level of the streaming Sobel edge magnitude block.
//
// Pixels enter on the req_ channel in raster order, one word per handshake;
// a word is taken when req_valid is high and req_stall is low. Results leave
// on the rsp_ channel with the centre column and row and a run_last flag on
// the final result a pixel causes (up to four: row end and last row flush).
// Registers sit on the csr_ port: image size, region of interest and the
// wide_output switch. Write them only while the block is idle.
//
// A pixel that yields no result passes through accept, shift and pick. Each
// result adds pick, gradient, one squaring stage, the 11-step square root
// (two radicand bits per cycle) and the load. The line stores are read at the
// accept edge and written in the shift state that follows.
//
// Reset clears the registers, window, counters and result valid flag; line
// stores need no clearing since no result reads an unwritten row. While the
// receiver stalls, the result holds and the block stops before its next load,
// so req_stall stays high while another result of the pixel waits to load.
module sobel_edge_magnitude (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sem_pkg::PIX_W-1:0]   req_pixel,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sem_pkg::MAG_W-1:0]   rsp_magnitude,
   output logic [sem_pkg::COL_W-1:0]   rsp_out_col,
   output logic [sem_pkg::ROW_W-1:0]   rsp_out_row,
   output logic                        rsp_run_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sem_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sem_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sem_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   sem_pkg::cfg_type    cfg;
   sem_pkg::cmd_type    cmd;
   sem_pkg::status_type status;

   // register bank
   sem_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: hold the input while a word is in flight
   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   sem_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// File: rtl/sem_checker.sv
// Port-level checks of the Sobel edge magnitude block, bound to the top level.
`include "assert_macros.svh"

module sem_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [sem_pkg::MAG_W-1:0]   rsp_magnitude,
   input logic [sem_pkg::COL_W-1:0]   rsp_out_col,
   input logic [sem_pkg::ROW_W-1:0]   rsp_out_row,
   input logic                        rsp_run_last
);

   logic [sem_pkg::MAG_W+sem_pkg::COL_W+sem_pkg::ROW_W:0] rsp_word;

   assign rsp_word = {rsp_magnitude, rsp_out_col, rsp_out_row, rsp_run_last};

   `SEM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `SEM_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_word), "stalled result changed")
   `SEM_ASSERT(a_mag_range, rsp_valid |-> rsp_magnitude <= 11'd1442, "magnitude out of range")
   `SEM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_magnitude (rsp_magnitude),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_row   (rsp_out_row),
   .rsp_run_last  (rsp_run_last)
);
